// ----- rtl/qll_pkg.sv -----
// Shared types, token codes and keyword table for the query language lexer.
// No dependencies; every other file of the block imports this package.
package qll_pkg;

    // Width of the running token length; it saturates at all ones.
    localparam int LEN_BITS    = 16;
    localparam int KW_MAX      = 12;
    localparam int KW_COUNT    = 52;
    localparam int KW_IDX_BITS = $clog2(KW_MAX);
    localparam int MAX_RES     = 3;
    localparam int KIND_BITS   = 7;

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    typedef logic [KIND_BITS-1:0] t_kind;
    typedef logic [LEN_BITS-1:0]  t_len;

    // Token codes below the keyword range.
    localparam t_kind K_SPACE   = 7'd0;
    localparam t_kind K_MINUS   = 7'd1;
    localparam t_kind K_QM      = 7'd2;
    localparam t_kind K_LP      = 7'd3;
    localparam t_kind K_RP      = 7'd4;
    localparam t_kind K_LB      = 7'd5;
    localparam t_kind K_RB      = 7'd6;
    localparam t_kind K_LC      = 7'd7;
    localparam t_kind K_RC      = 7'd8;
    localparam t_kind K_SEMI    = 7'd9;
    localparam t_kind K_PLUS    = 7'd10;
    localparam t_kind K_STAR    = 7'd11;
    localparam t_kind K_SLASH   = 7'd12;
    localparam t_kind K_REM     = 7'd13;
    localparam t_kind K_EQ      = 7'd14;
    localparam t_kind K_EQEQ    = 7'd15;
    localparam t_kind K_EQ3     = 7'd16;
    localparam t_kind K_LT      = 7'd17;
    localparam t_kind K_LE      = 7'd18;
    localparam t_kind K_NE      = 7'd19;
    localparam t_kind K_LSHIFT  = 7'd20;
    localparam t_kind K_GT      = 7'd21;
    localparam t_kind K_GE      = 7'd22;
    localparam t_kind K_RSHIFT  = 7'd23;
    localparam t_kind K_URSHIFT = 7'd24;
    localparam t_kind K_BANG    = 7'd25;
    localparam t_kind K_NE3     = 7'd26;
    localparam t_kind K_BITOR   = 7'd27;
    localparam t_kind K_OR      = 7'd28;
    localparam t_kind K_BITAND  = 7'd29;
    localparam t_kind K_AND     = 7'd30;
    localparam t_kind K_BITNOT  = 7'd31;
    localparam t_kind K_COMMA   = 7'd32;
    localparam t_kind K_COLON   = 7'd33;
    localparam t_kind K_STRING  = 7'd34;
    localparam t_kind K_DOT     = 7'd35;
    localparam t_kind K_INTEGER = 7'd36;
    localparam t_kind K_FLOAT   = 7'd37;
    localparam t_kind K_ID      = 7'd38;
    localparam t_kind K_ILLEGAL = 7'd39;

    // Lexer modes, one-hot.
    typedef enum logic [26:0] {
        M_IDLE      = 27'd1 << 0,
        M_SPACE     = 27'd1 << 1,
        M_MINUS1    = 27'd1 << 2,
        M_LINE      = 27'd1 << 3,
        M_SLASH1    = 27'd1 << 4,
        M_SLASHSTAR = 27'd1 << 5,
        M_BLOCK     = 27'd1 << 6,
        M_BLOCKSTAR = 27'd1 << 7,
        M_EQ1       = 27'd1 << 8,
        M_EQ2       = 27'd1 << 9,
        M_LT1       = 27'd1 << 10,
        M_GT1       = 27'd1 << 11,
        M_GT2       = 27'd1 << 12,
        M_BANG1     = 27'd1 << 13,
        M_BANG2     = 27'd1 << 14,
        M_BAR1      = 27'd1 << 15,
        M_AMP1      = 27'd1 << 16,
        M_STR       = 27'd1 << 17,
        M_DOT1      = 27'd1 << 18,
        M_INT       = 27'd1 << 19,
        M_FRAC      = 27'd1 << 20,
        M_EXP1      = 27'd1 << 21,
        M_EXP2P     = 27'd1 << 22,
        M_EXP2M     = 27'd1 << 23,
        M_EXPD      = 27'd1 << 24,
        M_BAD       = 27'd1 << 25,
        M_WORD      = 27'd1 << 26
    } t_mode;

    // Byte given back after a flush and lexed again.
    typedef enum logic [1:0] {
        REP_NONE,
        REP_STAR,
        REP_PLUS,
        REP_MINUS
    } t_rep;

    typedef struct packed {
        logic  last;
        t_kind kind;
        t_len  len;
    } t_tok;

    // All tokens produced by one accepted byte.
    typedef struct packed {
        logic [1:0]          cnt;
        t_tok [MAX_RES-1:0]  tok;
    } t_results;

    typedef logic [KW_MAX-1:0][7:0] t_wordbuf;

    // Keyword table: text (right-justified literal), length and token code.
    localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_COUNT] = '{
        "BEGIN", "INTO", "ORDER", "ROLLBACK", "ELSE", "SELECT", "GROUP",
        "UPDATE", "EACH", "HAVING", "GLOB", "BY", "WITHIN", "INSERT", "ALL",
        "LIMIT", "ASC", "ASCENDING", "ASYNC", "ASYNCHRONOUS", "AS",
        "SYNCHRONOUS", "SYNC", "COLLATE", "EXISTS", "COLLECTION", "NULL",
        "CREATE", "EXCEPT", "DELETE", "DESC", "DESCENDING", "DROP", "PRAGMA",
        "FLATTEN", "NOT", "IF", "FROM", "ILIKE", "LIKE", "UNION", "VALUE",
        "WHERE", "in", "null", "COMMIT", "DISTINCT", "INTERSECT", "OFFSET",
        "SET", "false", "true"
    };

    localparam logic [4:0] KW_LEN [KW_COUNT] = '{
        5'd5, 5'd4, 5'd5, 5'd8, 5'd4, 5'd6, 5'd5, 5'd6, 5'd4, 5'd6, 5'd4,
        5'd2, 5'd6, 5'd6, 5'd3, 5'd5, 5'd3, 5'd9, 5'd5, 5'd12, 5'd2, 5'd11,
        5'd4, 5'd7, 5'd6, 5'd10, 5'd4, 5'd6, 5'd6, 5'd6, 5'd4, 5'd10, 5'd4,
        5'd6, 5'd7, 5'd3, 5'd2, 5'd4, 5'd5, 5'd4, 5'd5, 5'd5, 5'd5, 5'd2,
        5'd4, 5'd6, 5'd8, 5'd9, 5'd6, 5'd3, 5'd5, 5'd4
    };

    localparam t_kind KW_CODE [KW_COUNT] = '{
        7'd40, 7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd49,
        7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd56, 7'd57, 7'd57,
        7'd58, 7'd59, 7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66,
        7'd67, 7'd67, 7'd68, 7'd69, 7'd48, 7'd70, 7'd71, 7'd72, 7'd73, 7'd50,
        7'd74, 7'd75, 7'd76, 7'd77, 7'd63, 7'd78, 7'd79, 7'd80, 7'd81, 7'd82,
        7'd83, 7'd84
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_digit(c) || ((c >= "A") && (c <= "Z")) ||
               ((c >= "a") && (c <= "z")) || (c == "_") || c[7];
    endfunction

endpackage

// ----- rtl/qll_kwmatch.sv -----
// Parallel keyword compare of the identifier buffer against the keyword table.
// Depends on qll_pkg for the table and buffer type.
module qll_kwmatch
    import qll_pkg::*;
(
    input  t_wordbuf i_buf,
    input  t_len     i_len,
    output t_kind    o_kind
);

    // Every keyword is compared at once; short or over-long words stay identifiers.
    always_comb begin
        logic found;
        logic hit;
        int   pos;
        found  = 1'b0;
        o_kind = K_ID;
        for (int k = 0; k < KW_COUNT; k++) begin
            hit = (i_len == LEN_BITS'(KW_LEN[k]));
            for (int b = 0; b < KW_MAX; b++) begin
                if (b < int'(KW_LEN[k])) begin
                    pos = 8 * (int'(KW_LEN[k]) - 1 - b);
                    hit = hit && (i_buf[b] == KW_TEXT[k][pos +: 8]);
                end
            end
            if (hit && !found && (i_len >= LEN_BITS'(2))) begin
                found  = 1'b1;
                o_kind = KW_CODE[k];
            end
        end
    end

endmodule

// ----- rtl/qll_core.sv -----
// Lexer state registers and the per-byte next-state and token logic.
// Depends on qll_pkg and instantiates qll_kwmatch.
module qll_core
    import qll_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_results   o_res
);

    t_mode    r_mode, n_mode;
    t_len     r_len, n_len;
    logic     r_esc, n_esc;
    t_wordbuf r_buf;
    logic     buf_we;
    logic [KW_IDX_BITS-1:0] buf_idx;
    t_kind    word_kind;

    qll_kwmatch u_kwmatch (
        .i_buf  (r_buf),
        .i_len  (r_len),
        .o_kind (word_kind)
    );

    // Token and state update for one byte: continue, or flush, replay and restart.
    always_comb begin
        t_tok       tk [MAX_RES];
        logic [1:0] cnt;
        logic       do_flush;
        logic       do_start;
        t_len       grown;
        t_kind      fl_kind;
        t_len       fl_len;
        t_rep       fl_rep;
        logic       st_emit;
        t_kind      st_kind;
        t_mode      st_mode;

        cnt      = 2'd0;
        do_flush = 1'b0;
        do_start = 1'b0;
        n_mode   = r_mode;
        n_len    = r_len;
        n_esc    = r_esc;
        buf_we   = 1'b0;
        buf_idx  = '0;
        grown    = (r_len == LEN_MAX) ? r_len : r_len + LEN_BITS'(1);
        for (int i = 0; i < MAX_RES; i++) begin
            tk[i] = '0;
        end

        // Token that closes the open one as it stands.
        fl_len = r_len;
        fl_rep = REP_NONE;
        case (r_mode)
            M_SPACE, M_LINE, M_BLOCK, M_BLOCKSTAR: fl_kind = K_SPACE;
            M_MINUS1:    begin fl_kind = K_MINUS;  fl_len = LEN_BITS'(1); end
            M_SLASH1:    begin fl_kind = K_SLASH;  fl_len = LEN_BITS'(1); end
            M_SLASHSTAR: begin
                fl_kind = K_SLASH;
                fl_len  = LEN_BITS'(1);
                fl_rep  = REP_STAR;
            end
            M_EQ1:       begin fl_kind = K_EQ;     fl_len = LEN_BITS'(1); end
            M_EQ2:       begin fl_kind = K_EQEQ;   fl_len = LEN_BITS'(2); end
            M_LT1:       begin fl_kind = K_LT;     fl_len = LEN_BITS'(1); end
            M_GT1:       begin fl_kind = K_GT;     fl_len = LEN_BITS'(1); end
            M_GT2:       begin fl_kind = K_RSHIFT; fl_len = LEN_BITS'(2); end
            M_BANG1:     begin fl_kind = K_BANG;   fl_len = LEN_BITS'(1); end
            M_BANG2:     begin fl_kind = K_NE;     fl_len = LEN_BITS'(2); end
            M_BAR1:      begin fl_kind = K_BITOR;  fl_len = LEN_BITS'(1); end
            M_AMP1:      begin fl_kind = K_BITAND; fl_len = LEN_BITS'(1); end
            M_STR:       fl_kind = K_STRING;
            M_DOT1:      begin fl_kind = K_DOT;    fl_len = LEN_BITS'(1); end
            M_INT:       fl_kind = K_INTEGER;
            M_FRAC, M_EXPD: fl_kind = K_FLOAT;
            M_EXP1, M_BAD:  fl_kind = K_ILLEGAL;
            M_EXP2P, M_EXP2M: begin
                // The sign is given back; a saturated count stays saturated.
                fl_kind = K_ILLEGAL;
                if ((r_len != LEN_MAX) && (r_len != '0)) begin
                    fl_len = r_len - LEN_BITS'(1);
                end
                fl_rep = (r_mode == M_EXP2P) ? REP_PLUS : REP_MINUS;
            end
            M_WORD:      fl_kind = word_kind;
            default:     fl_kind = K_ILLEGAL;
        endcase

        // What the byte does as the first byte of a token.
        st_emit = 1'b1;
        st_mode = M_IDLE;
        st_kind = K_ILLEGAL;
        case (i_byte)
            " ", 8'h09, 8'h0A, 8'h0C, 8'h0D: begin st_emit = 1'b0; st_mode = M_SPACE; end
            "-":  begin st_emit = 1'b0; st_mode = M_MINUS1; end
            "/":  begin st_emit = 1'b0; st_mode = M_SLASH1; end
            "=":  begin st_emit = 1'b0; st_mode = M_EQ1;    end
            "<":  begin st_emit = 1'b0; st_mode = M_LT1;    end
            ">":  begin st_emit = 1'b0; st_mode = M_GT1;    end
            "!":  begin st_emit = 1'b0; st_mode = M_BANG1;  end
            "|":  begin st_emit = 1'b0; st_mode = M_BAR1;   end
            "&":  begin st_emit = 1'b0; st_mode = M_AMP1;   end
            "\"": begin st_emit = 1'b0; st_mode = M_STR;    end
            ".":  begin st_emit = 1'b0; st_mode = M_DOT1;   end
            "?":  st_kind = K_QM;
            "(":  st_kind = K_LP;
            ")":  st_kind = K_RP;
            "[":  st_kind = K_LB;
            "]":  st_kind = K_RB;
            "{":  st_kind = K_LC;
            "}":  st_kind = K_RC;
            ";":  st_kind = K_SEMI;
            "+":  st_kind = K_PLUS;
            "*":  st_kind = K_STAR;
            "%":  st_kind = K_REM;
            ",":  st_kind = K_COMMA;
            ":":  st_kind = K_COLON;
            "~":  st_kind = K_BITNOT;
            default: begin
                if (is_digit(i_byte)) begin
                    st_emit = 1'b0;
                    st_mode = M_INT;
                end else if (is_ident(i_byte)) begin
                    st_emit = 1'b0;
                    st_mode = M_WORD;
                end
            end
        endcase

        if (r_mode == M_IDLE) begin
            do_start = !i_end;
        end else if (i_end) begin
            do_flush = 1'b1;
        end else begin
            // Assume the byte closes the token; the arms below clear this.
            do_flush = 1'b1;
            do_start = 1'b1;
            case (r_mode)
                M_SPACE: begin
                    if (is_space(i_byte)) begin do_flush = 1'b0; n_len = grown; end
                end
                M_MINUS1: begin
                    if (i_byte == "-") begin
                        do_flush = 1'b0; n_mode = M_LINE; n_len = grown;
                    end
                end
                M_LINE: begin
                    if (i_byte != 8'h0A) begin do_flush = 1'b0; n_len = grown; end
                end
                M_SLASH1: begin
                    if (i_byte == "*") begin
                        do_flush = 1'b0; n_mode = M_SLASHSTAR; n_len = grown;
                    end
                end
                M_SLASHSTAR, M_BLOCK: begin
                    do_flush = 1'b0;
                    n_len    = grown;
                    n_mode   = (i_byte == "*") ? M_BLOCKSTAR : M_BLOCK;
                end
                M_BLOCKSTAR: begin
                    do_flush = 1'b0;
                    n_len    = grown;
                    n_mode   = (i_byte == "*") ? M_BLOCKSTAR : M_BLOCK;
                    if (i_byte == "/") begin
                        tk[cnt] = '{last: 1'b0, kind: K_SPACE, len: grown};
                        cnt     = cnt + 2'd1;
                        n_mode  = M_IDLE;
                        n_len   = '0;
                        n_esc   = 1'b0;
                    end
                end
                M_EQ1: begin
                    if (i_byte == "=") begin do_flush = 1'b0; n_mode = M_EQ2; end
                end
                M_EQ2, M_BANG2: begin
                    if (i_byte == "=") begin
                        do_flush = 1'b0;
                        tk[cnt]  = '{last: 1'b0,
                                     kind: (r_mode == M_EQ2) ? K_EQ3 : K_NE3,
                                     len: LEN_BITS'(3)};
                        cnt      = cnt + 2'd1;
                        n_mode   = M_IDLE;
                        n_len    = '0;
                    end
                end
                M_LT1: begin
                    if ((i_byte == "=") || (i_byte == ">") || (i_byte == "<")) begin
                        do_flush = 1'b0;
                        tk[cnt]  = '{last: 1'b0,
                                     kind: (i_byte == "=") ? K_LE :
                                           (i_byte == ">") ? K_NE : K_LSHIFT,
                                     len: LEN_BITS'(2)};
                        cnt      = cnt + 2'd1;
                        n_mode   = M_IDLE;
                        n_len    = '0;
                    end
                end
                M_GT1: begin
                    if (i_byte == "=") begin
                        do_flush = 1'b0;
                        tk[cnt]  = '{last: 1'b0, kind: K_GE, len: LEN_BITS'(2)};
                        cnt      = cnt + 2'd1;
                        n_mode   = M_IDLE;
                        n_len    = '0;
                    end else if (i_byte == ">") begin
                        do_flush = 1'b0;
                        n_mode   = M_GT2;
                    end
                end
                M_GT2: begin
                    if (i_byte == ">") begin
                        do_flush = 1'b0;
                        tk[cnt]  = '{last: 1'b0, kind: K_URSHIFT, len: LEN_BITS'(3)};
                        cnt      = cnt + 2'd1;
                        n_mode   = M_IDLE;
                        n_len    = '0;
                    end
                end
                M_BANG1: begin
                    if (i_byte == "=") begin do_flush = 1'b0; n_mode = M_BANG2; end
                end
                M_BAR1, M_AMP1: begin
                    if (((r_mode == M_BAR1) && (i_byte == "|")) ||
                        ((r_mode == M_AMP1) && (i_byte == "&"))) begin
                        do_flush = 1'b0;
                        tk[cnt]  = '{last: 1'b0,
                                     kind: (r_mode == M_BAR1) ? K_OR : K_AND,
                                     len: LEN_BITS'(2)};
                        cnt      = cnt + 2'd1;
                        n_mode   = M_IDLE;
                        n_len    = '0;
                    end
                end
                M_STR: begin
                    do_flush = 1'b0;
                    n_len    = grown;
                    if (r_esc) begin
                        n_esc = 1'b0;
                    end else if (i_byte == "\"") begin
                        tk[cnt] = '{last: 1'b0, kind: K_STRING, len: grown};
                        cnt     = cnt + 2'd1;
                        n_mode  = M_IDLE;
                        n_len   = '0;
                    end else if (i_byte == "\\") begin
                        n_esc = 1'b1;
                    end
                end
                M_DOT1: begin
                    if (is_digit(i_byte)) begin
                        do_flush = 1'b0; n_mode = M_FRAC; n_len = grown;
                    end
                end
                M_INT, M_FRAC: begin
                    if (is_digit(i_byte)) begin
                        do_flush = 1'b0; n_len = grown;
                    end else if ((i_byte == ".") && (r_mode == M_INT)) begin
                        do_flush = 1'b0; n_mode = M_FRAC; n_len = grown;
                    end else if ((i_byte == "e") || (i_byte == "E")) begin
                        do_flush = 1'b0; n_mode = M_EXP1; n_len = grown;
                    end else if (is_ident(i_byte)) begin
                        do_flush = 1'b0; n_mode = M_BAD; n_len = grown;
                    end
                end
                M_EXP1: begin
                    if (is_digit(i_byte)) begin
                        do_flush = 1'b0; n_mode = M_EXPD; n_len = grown;
                    end else if ((i_byte == "+") || (i_byte == "-")) begin
                        do_flush = 1'b0;
                        n_mode   = (i_byte == "+") ? M_EXP2P : M_EXP2M;
                        n_len    = grown;
                    end else if (is_ident(i_byte)) begin
                        do_flush = 1'b0; n_mode = M_BAD; n_len = grown;
                    end
                end
                M_EXP2P, M_EXP2M: begin
                    if (is_digit(i_byte)) begin
                        do_flush = 1'b0; n_mode = M_EXPD; n_len = grown;
                    end
                end
                M_EXPD: begin
                    if (is_digit(i_byte)) begin
                        do_flush = 1'b0; n_len = grown;
                    end else if (is_ident(i_byte)) begin
                        do_flush = 1'b0; n_mode = M_BAD; n_len = grown;
                    end
                end
                M_BAD: begin
                    if (is_ident(i_byte)) begin do_flush = 1'b0; n_len = grown; end
                end
                M_WORD: begin
                    if (is_ident(i_byte)) begin
                        do_flush = 1'b0;
                        n_len    = grown;
                        if (r_len < LEN_BITS'(KW_MAX)) begin
                            buf_we  = 1'b1;
                            buf_idx = r_len[KW_IDX_BITS-1:0];
                        end
                    end
                end
                default: begin
                    do_flush = 1'b0;
                    do_start = 1'b0;
                    n_mode   = M_IDLE;
                    n_len    = '0;
                    n_esc    = 1'b0;
                end
            endcase
            if (do_flush == 1'b0) begin
                do_start = 1'b0;
            end
        end

        // Close the token, then lex any byte it gives back.
        if (do_flush) begin
            tk[cnt] = '{last: 1'b0, kind: fl_kind, len: fl_len};
            cnt     = cnt + 2'd1;
            n_mode  = M_IDLE;
            n_len   = '0;
            n_esc   = 1'b0;
            case (fl_rep)
                REP_STAR: begin
                    tk[cnt] = '{last: 1'b0, kind: K_STAR, len: LEN_BITS'(1)};
                    cnt     = cnt + 2'd1;
                end
                REP_PLUS: begin
                    tk[cnt] = '{last: 1'b0, kind: K_PLUS, len: LEN_BITS'(1)};
                    cnt     = cnt + 2'd1;
                end
                REP_MINUS: begin
                    // A replayed minus followed by a minus opens a line comment.
                    if (!i_end && (i_byte == "-")) begin
                        n_mode   = M_LINE;
                        n_len    = LEN_BITS'(2);
                        do_start = 1'b0;
                    end else begin
                        tk[cnt] = '{last: 1'b0, kind: K_MINUS, len: LEN_BITS'(1)};
                        cnt     = cnt + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        // Lex the byte afresh.
        if (do_start) begin
            if (st_emit) begin
                tk[cnt] = '{last: 1'b0, kind: st_kind, len: LEN_BITS'(1)};
                cnt     = cnt + 2'd1;
            end else begin
                n_mode = st_mode;
                n_len  = LEN_BITS'(1);
                n_esc  = 1'b0;
                if (st_mode == M_WORD) begin
                    buf_we  = 1'b1;
                    buf_idx = '0;
                end
            end
        end

        o_res.cnt = cnt;
        for (int i = 0; i < MAX_RES; i++) begin
            o_res.tok[i]      = tk[i];
            o_res.tok[i].last = (cnt != 2'd0) && (2'(i) == (cnt - 2'd1));
        end
    end

    // State registers advance on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_len  <= '0;
            r_esc  <= 1'b0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_esc  <= n_esc;
        end
    end

    // Identifier buffer, no reset.
    always_ff @(posedge i_clk) begin
        if (i_accept && buf_we) begin
            r_buf[buf_idx] <= i_byte;
        end
    end

endmodule

// ----- rtl/qll_outbuf.sv -----
// Result register for up to three tokens, drained one transfer per cycle while i_ready is high.
// Depends on qll_pkg for the token and result types.
module qll_outbuf
    import qll_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_results i_res,
    output logic     o_can_load,
    output logic     o_valid,
    input  logic     i_ready,
    output t_tok     o_tok
);

    t_tok       r_q [MAX_RES];
    logic [1:0] r_cnt;
    logic       pop;

    assign pop        = (r_cnt != 2'd0) && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_tok      = r_q[0];

    // Occupancy count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load && (i_res.cnt != 2'd0)) begin
            r_cnt <= i_res.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Token slots: load a new group or shift toward the head.
    always_ff @(posedge i_clk) begin
        if (i_load && (i_res.cnt != 2'd0)) begin
            for (int i = 0; i < MAX_RES; i++) begin
                r_q[i] <= i_res.tok[i];
            end
        end else if (pop) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                r_q[i] <= r_q[i+1];
            end
        end
    end

endmodule

// ----- rtl/query_language_lexer.sv -----
// Query language lexer: takes one text byte per transfer and emits tokens.
// Depends on qll_pkg; instantiates qll_core and qll_outbuf.
//
// One byte (or the end marker on tlast) is taken per cycle while tready is high;
// each byte is lexed combinationally from the state register into a result
// register that holds the up to three tokens the byte closes. Tokens leave one
// per cycle while the output is ready, so a byte yielding two or more tokens
// holds the input while the result register drains; bytes yielding zero or one
// token then flow at one per cycle with no bubbles. Token length saturates at
// 65535, identifiers over 12 bytes are never keywords, and the last token of
// each byte carries tlast. No clearing pass is needed after reset.
module query_language_lexer
    import qll_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] text_byte
    input  logic        i_s_axis_tlast,   // end_of_text
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [6:0] token_kind, [22:7] token_length
    output logic        o_m_axis_tlast    // last_of_run
);

    t_results res;
    t_tok     head;
    logic     can_load;
    logic     accept;

    assign o_s_axis_tready = can_load;
    assign accept          = i_s_axis_tvalid && can_load;

    qll_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_end    (i_s_axis_tlast),
        .o_res    (res)
    );

    qll_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_res      (res),
        .o_can_load (can_load),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_tok      (head)
    );

    // Pack the head token for the output transfer.
    assign o_m_axis_tdata = {1'b0, head.len, head.kind};
    assign o_m_axis_tlast = head.last;

endmodule
